[sv/bpt_pkg.sv]
// Shared widths, control struct and output saturation for the barometric
// pressure/temperature compensation pipeline.
// No dependencies.
package bpt_pkg;

    // Field widths
    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int OUT_W    = 32;

    // Datapath widths shared between the front and the pressure back end
    localparam int OFF_W    = 40;  // OFF, signed
    localparam int SENS_W   = 39;  // SENS, signed
    localparam int Q_W      = 19;  // truncated temperature offsets, signed
    localparam int SAT_IN_W = 48;  // input width of the saturation function

    // Register stages in the pressure back end, input to registered result
    localparam int PRESS_LAT = 6;

    // Control that travels with each request through the back end
    typedef struct packed {
        logic valid;
        logic press_zero;
    } bpt_ctl_t;

    // Clamp a wide signed value to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic [SAT_IN_W-OUT_W:0] upper;
        logic signed [OUT_W-1:0] res;
        upper = v[SAT_IN_W-1:OUT_W-1];
        if ((&upper) || !(|upper)) begin
            res = v[OUT_W-1:0];
        end
        else if (v[SAT_IN_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

[sv/baro_pressure_temp_compensation_unit.sv]
// Top level of the barometric pressure/temperature compensation pipeline:
// calibration registers, dT, temperature, OFF/SENS front end.
// Depends on bpt_pkg and bpt_press.

// One raw pressure/temperature pair enters per clock; busy is never
// asserted, so start can be held high every cycle. result_valid marks
// each result for a single cycle and cannot be held off, so the receiver
// must take it then. The pipeline has nine register stages: dT, the dT
// products, temperature and OFF/SENS, the correction squares, terms and
// corrected OFF/SENS, the D1 x SENS partial products, their recombination
// and the final shift and clamp. Calibration words are written over the
// APB port, at byte address 4*i for word Ci+1; the user must write them
// only while no request is in flight, as the block does not enforce this.
module baro_pressure_temp_compensation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [bpt_pkg::RAW_W-1:0]           raw_pressure,
    input  logic [bpt_pkg::RAW_W-1:0]           raw_temperature,
    output logic                                result_valid,
    output logic signed [bpt_pkg::OUT_W-1:0]    temperature_centi,
    output logic signed [bpt_pkg::OUT_W-1:0]    pressure_centi_mbar,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import bpt_pkg::*;

    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    localparam int DT_W    = RAW_W + 1;
    localparam int MT_W    = DT_W + CAL_W + 1;
    localparam int MSQ_W   = 2 * DT_W - 1;
    localparam int T_SHIFT = 23;
    localparam int T2_SHIFT = 31;
    localparam int TFL_W   = MT_W - T_SHIFT;
    localparam int T2_W    = MSQ_W - T2_SHIFT;
    localparam int TB_W    = TFL_W + 1;
    localparam int TV_W    = TB_W + 1;
    localparam int OFF_SH  = 7;
    localparam int SENS_SH = 8;
    localparam int ACCEPT_TO_OUT = 3 + PRESS_LAT;

    localparam logic signed [TB_W-1:0] T_REF   = TB_W'(2000);
    localparam logic signed [Q_W-1:0]  T_COLD  = Q_W'(3500);

    // Calibration words
    logic [CAL_W-1:0] cal_pressure_sensitivity_reg;
    logic [CAL_W-1:0] cal_pressure_offset_reg;
    logic [CAL_W-1:0] cal_sens_temp_coeff_reg;
    logic [CAL_W-1:0] cal_offset_temp_coeff_reg;
    logic [CAL_W-1:0] cal_reference_temp_reg;
    logic [CAL_W-1:0] cal_temp_sensitivity_reg;
    logic             cfg_write;

    // Stage valid bits
    logic v1_reg, v2_reg;
    bpt_ctl_t ctl3_reg, ctl3_next;
    logic accept;

    // Stage 1: dT
    logic signed [DT_W-1:0]  dt_diff;
    logic signed [DT_W-1:0]  dt1_reg, dt1_next;
    logic                    tz1_reg, tz1_next;
    logic                    pz1_reg, pz1_next;
    logic [RAW_W-1:0]        d1_1_reg;

    // Stage 2: dT products
    logic signed [MT_W-1:0]   mt2_reg, mt2_next;
    logic signed [MT_W-1:0]   mo2_reg, mo2_next;
    logic signed [MT_W-1:0]   ms2_reg, ms2_next;
    logic signed [2*DT_W-1:0] dsq;
    logic [MSQ_W-1:0]         msq2_reg, msq2_next;
    logic                     tz2_reg, pz2_reg;
    logic [RAW_W-1:0]         d1_2_reg;

    // Stage 3: temperature, OFF, SENS, truncated offsets
    logic signed [TFL_W-1:0]  mt_fl;
    logic signed [TB_W-1:0]   temp_base;
    logic [T2_W-1:0]          t2;
    logic signed [TV_W-1:0]   temp_val;
    logic signed [Q_W-1:0]    q, qb;
    logic                     rnd;
    logic signed [OUT_W-1:0]  temp3_reg, temp3_next;
    logic signed [OFF_W-1:0]  off3_reg, off3_next;
    logic signed [SENS_W-1:0] sens3_reg, sens3_next;
    logic signed [Q_W-1:0]    qa3_reg, qa3_next, qb3_reg, qb3_next;
    logic [RAW_W-1:0]         d1_3_reg;

    // Temperature wait line, aligned with the pressure back end
    logic signed [OUT_W-1:0]  temp_dly_reg [PRESS_LAT];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    // Write calibration words
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_pressure_sensitivity_reg <= '0;
            cal_pressure_offset_reg      <= '0;
            cal_sens_temp_coeff_reg      <= '0;
            cal_offset_temp_coeff_reg    <= '0;
            cal_reference_temp_reg       <= '0;
            cal_temp_sensitivity_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_C1:  cal_pressure_sensitivity_reg <= pwdata[CAL_W-1:0];
                REG_C2:  cal_pressure_offset_reg      <= pwdata[CAL_W-1:0];
                REG_C3:  cal_sens_temp_coeff_reg      <= pwdata[CAL_W-1:0];
                REG_C4:  cal_offset_temp_coeff_reg    <= pwdata[CAL_W-1:0];
                REG_C5:  cal_reference_temp_reg       <= pwdata[CAL_W-1:0];
                REG_C6:  cal_temp_sensitivity_reg     <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back calibration words
    always_comb
    begin
        unique case (paddr[4:2])
            REG_C1:  prdata = 32'(cal_pressure_sensitivity_reg);
            REG_C2:  prdata = 32'(cal_pressure_offset_reg);
            REG_C3:  prdata = 32'(cal_sens_temp_coeff_reg);
            REG_C4:  prdata = 32'(cal_offset_temp_coeff_reg);
            REG_C5:  prdata = 32'(cal_reference_temp_reg);
            REG_C6:  prdata = 32'(cal_temp_sensitivity_reg);
            default: prdata = '0;
        endcase
    end

    // dT = D2 - C5*256, forced to zero when D2 is zero
    assign dt_diff  = $signed({1'b0, raw_temperature})
                    - $signed({1'b0, cal_reference_temp_reg, 8'h00});
    assign dt1_next = (raw_temperature == '0) ? '0 : dt_diff;
    assign tz1_next = (raw_temperature == '0) || (dt_diff == '0);
    assign pz1_next = tz1_next || (raw_pressure == '0);

    // Products of dT
    assign mt2_next  = dt1_reg * $signed({1'b0, cal_temp_sensitivity_reg});
    assign mo2_next  = dt1_reg * $signed({1'b0, cal_offset_temp_coeff_reg});
    assign ms2_next  = dt1_reg * $signed({1'b0, cal_sens_temp_coeff_reg});
    assign dsq       = dt1_reg * dt1_reg;
    assign msq2_next = dsq[MSQ_W-1:0];

    // Temperature with the cold correction
    assign mt_fl     = mt2_reg[MT_W-1:T_SHIFT];
    assign temp_base = {mt_fl[TFL_W-1], mt_fl} + T_REF;
    assign t2        = mt_fl[TFL_W-1] ? msq2_reg[MSQ_W-1:T2_SHIFT] : '0;
    assign temp_val  = {temp_base[TB_W-1], temp_base} - {{(TV_W-T2_W){1'b0}}, t2};
    assign temp3_next = tz2_reg ? '0
                      : sat_out({{(SAT_IN_W-TV_W){temp_val[TV_W-1]}}, temp_val});

    // OFF = C2*65536 + (C4*dT >> 7), SENS = C1*32768 + (C3*dT >> 8)
    assign off3_next  = {{(OFF_W-CAL_W-16){1'b0}}, cal_pressure_offset_reg, 16'h0000}
                      + {{(OFF_W-(MT_W-OFF_SH)){mo2_reg[MT_W-1]}}, mo2_reg[MT_W-1:OFF_SH]};
    assign sens3_next = {{(SENS_W-CAL_W-15){1'b0}}, cal_pressure_sensitivity_reg, 15'h0000}
                      + {{(SENS_W-(MT_W-SENS_SH)){ms2_reg[MT_W-1]}}, ms2_reg[MT_W-1:SENS_SH]};

    // Truncating division by 2**23 for the pressure corrections
    assign rnd      = mt2_reg[MT_W-1] && (|mt2_reg[T_SHIFT-1:0]);
    assign q        = mt_fl + Q_W'(rnd);
    assign qb       = q + T_COLD;
    assign qa3_next = q[Q_W-1] ? q : '0;
    assign qb3_next = qb[Q_W-1] ? qb : '0;

    always_comb
    begin
        ctl3_next.valid      = v2_reg;
        ctl3_next.press_zero = pz2_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        dt1_reg   <= dt1_next;
        tz1_reg   <= tz1_next;
        pz1_reg   <= pz1_next;
        d1_1_reg  <= raw_pressure;

        mt2_reg   <= mt2_next;
        mo2_reg   <= mo2_next;
        ms2_reg   <= ms2_next;
        msq2_reg  <= msq2_next;
        tz2_reg   <= tz1_reg;
        pz2_reg   <= pz1_reg;
        d1_2_reg  <= d1_1_reg;

        temp3_reg <= temp3_next;
        off3_reg  <= off3_next;
        sens3_reg <= sens3_next;
        qa3_reg   <= qa3_next;
        qb3_reg   <= qb3_next;
        d1_3_reg  <= d1_2_reg;
    end

    // Hold temperature until the matching pressure is ready
    always_ff @(posedge clk)
    begin
        temp_dly_reg[0] <= temp3_reg;
        for (int i = 1; i < PRESS_LAT; i++)
        begin
            temp_dly_reg[i] <= temp_dly_reg[i-1];
        end
    end

    bpt_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl3_reg),
        .d1        (d1_3_reg),
        .off       (off3_reg),
        .sens      (sens3_reg),
        .qa        (qa3_reg),
        .qb        (qb3_reg),
        .res_valid (result_valid),
        .pressure  (pressure_centi_mbar)
    );

    assign temperature_centi = temp_dly_reg[PRESS_LAT-1];

    // Every result traces back to a request a fixed latency earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, ACCEPT_TO_OUT))
        else $error("result without a matching request");

    // Temperature stays well inside its datapath range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (temperature_centi < 32'sd524288)
                      && (temperature_centi > -32'sd524288))
        else $error("temperature outside expected range");

    // Pressure stays well inside its datapath range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pressure_centi_mbar < 32'sd268435456)
                      && (pressure_centi_mbar > -32'sd268435456))
        else $error("pressure outside expected range");

endmodule

[sv/bpt_press.sv]
// Pressure back end: second-order OFF2/SENS2 corrections, the D1 x SENS
// product in two partial products, final shift and saturation.
// Depends on bpt_pkg.
module bpt_press (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpt_pkg::bpt_ctl_t                   ctl,
    input  logic [bpt_pkg::RAW_W-1:0]           d1,
    input  logic signed [bpt_pkg::OFF_W-1:0]    off,
    input  logic signed [bpt_pkg::SENS_W-1:0]   sens,
    input  logic signed [bpt_pkg::Q_W-1:0]      qa,
    input  logic signed [bpt_pkg::Q_W-1:0]      qb,
    output logic                                res_valid,
    output logic signed [bpt_pkg::OUT_W-1:0]    pressure
);
    import bpt_pkg::*;

    localparam int SQ_W    = 2 * Q_W - 3;    // squares stay below 2**35
    localparam int CORR_W  = 39;             // OFF2 / SENS2, unsigned
    localparam int OFFC_W  = OFF_W + 1;
    localparam int SENSC_W = SENS_W + 1;
    localparam int HALF_W  = 20;             // low slice of SENS for the split product
    localparam int PLO_W   = RAW_W + HALF_W;
    localparam int PHI_W   = RAW_W + 1 + (SENSC_W - HALF_W);
    localparam int PROD_W  = PHI_W + HALF_W;
    localparam int P_SHIFT = 21;
    localparam int F_SHIFT = 15;
    localparam int ACC_W   = PROD_W - P_SHIFT + 1;
    localparam int PF_W    = ACC_W - F_SHIFT;

    // Stage valid/flag registers
    bpt_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;

    // Stage 1: squares
    logic [RAW_W-1:0]            d1_1_reg;
    logic signed [OFF_W-1:0]     off1_reg;
    logic signed [SENS_W-1:0]    sens1_reg;
    logic [SQ_W-1:0]             sqa1_reg, sqb1_reg;
    logic [SQ_W-1:0]             sqa1_next, sqb1_next;
    logic signed [2*Q_W-1:0]     sqa_full, sqb_full;

    // Stage 2: correction terms
    logic [RAW_W-1:0]            d1_2_reg;
    logic signed [OFF_W-1:0]     off2_reg;
    logic signed [SENS_W-1:0]    sens2_reg;
    logic [CORR_W-1:0]           offcor2_reg, senscor2_reg;
    logic [CORR_W-1:0]           offcor2_next, senscor2_next;
    logic [CORR_W-1:0]           sqa_e, sqb_e, sqa_x5, sqb_x7, sqb_x11;

    // Stage 3: corrected OFF and SENS
    logic [RAW_W-1:0]            d1_3_reg;
    logic signed [OFFC_W-1:0]    offc3_reg, offc3_next;
    logic signed [SENSC_W-1:0]   sensc3_reg, sensc3_next;

    // Stage 4: partial products
    logic signed [OFFC_W-1:0]    offc4_reg;
    logic [PLO_W-1:0]            plo4_reg, plo4_next;
    logic signed [PHI_W-1:0]     phi4_reg, phi4_next;

    // Stage 5: recombine, shift, subtract OFF
    logic [PROD_W-1:0]           prod;
    logic signed [ACC_W-1:0]     acc5_reg, acc5_next;

    // Stage 6: final shift and clamp
    logic signed [OUT_W-1:0]     press6_reg, press6_next;
    logic signed [SAT_IN_W-1:0]  sat_in;

    // Squares of the low-temperature offsets
    assign sqa_full  = qa * qa;
    assign sqb_full  = qb * qb;
    assign sqa1_next = sqa_full[SQ_W-1:0];
    assign sqb1_next = sqb_full[SQ_W-1:0];

    // OFF2 = 5*sqa/2 + 7*sqb, SENS2 = 5*sqa/4 + 11*sqb/2
    assign sqa_e         = {{(CORR_W-SQ_W){1'b0}}, sqa1_reg};
    assign sqb_e         = {{(CORR_W-SQ_W){1'b0}}, sqb1_reg};
    assign sqa_x5        = (sqa_e << 2) + sqa_e;
    assign sqb_x7        = (sqb_e << 3) - sqb_e;
    assign sqb_x11       = (sqb_e << 3) + (sqb_e << 1) + sqb_e;
    assign offcor2_next  = (sqa_x5 >> 1) + sqb_x7;
    assign senscor2_next = (sqa_x5 >> 2) + (sqb_x11 >> 1);

    // Apply the corrections
    assign offc3_next  = {off2_reg[OFF_W-1], off2_reg}
                       - {{(OFFC_W-CORR_W){1'b0}}, offcor2_reg};
    assign sensc3_next = {sens2_reg[SENS_W-1], sens2_reg}
                       - {{(SENSC_W-CORR_W){1'b0}}, senscor2_reg};

    // Split D1 x SENS into an unsigned low and a signed high partial product
    assign plo4_next = PLO_W'(d1_3_reg) * PLO_W'(sensc3_reg[HALF_W-1:0]);
    assign phi4_next = $signed({1'b0, d1_3_reg}) * $signed(sensc3_reg[SENSC_W-1:HALF_W]);

    // Recombine, floor shift by 21, subtract OFF
    assign prod      = {phi4_reg, {HALF_W{1'b0}}} + PROD_W'(plo4_reg);
    assign acc5_next = {prod[PROD_W-1], prod[PROD_W-1:P_SHIFT]}
                     - {{(ACC_W-OFFC_W){offc4_reg[OFFC_W-1]}}, offc4_reg};

    // Floor shift by 15 and clamp; zero when forced
    assign sat_in      = {{(SAT_IN_W-PF_W){acc5_reg[ACC_W-1]}}, acc5_reg[ACC_W-1:F_SHIFT]};
    assign press6_next = ctl5_reg.press_zero ? '0 : sat_out(sat_in);

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        d1_1_reg     <= d1;
        off1_reg     <= off;
        sens1_reg    <= sens;
        sqa1_reg     <= sqa1_next;
        sqb1_reg     <= sqb1_next;

        d1_2_reg     <= d1_1_reg;
        off2_reg     <= off1_reg;
        sens2_reg    <= sens1_reg;
        offcor2_reg  <= offcor2_next;
        senscor2_reg <= senscor2_next;

        d1_3_reg     <= d1_2_reg;
        offc3_reg    <= offc3_next;
        sensc3_reg   <= sensc3_next;

        offc4_reg    <= offc3_reg;
        plo4_reg     <= plo4_next;
        phi4_reg     <= phi4_next;

        acc5_reg     <= acc5_next;

        press6_reg   <= press6_next;
    end

    assign res_valid = ctl6_reg.valid;
    assign pressure  = press6_reg;

endmodule
